FILE: rtl/core/dary_min_heap_queue_top_defines.svh
// Assertion macros used by the heap queue engine RTL.
`ifndef DARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH
`define DARY_MIN_HEAP_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DMHQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DMHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/dmhq_pkg.sv
// Types, constants and index helpers for the d-ary min-heap queue.
`default_nettype none

package dmhq_pkg;

  localparam int ARITY    = 3;
  localparam int CAPACITY = 64;

  localparam int KEY_W = 32;
  localparam int EC_W  = 7;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CHW   = $clog2(CAPACITY * ARITY + 1);

  // parent = (pos - 1) / ARITY by reciprocal multiply, exact for IDX_W-bit values
  localparam int UP_SH  = IDX_W + $clog2(ARITY);
  localparam int UP_MUL = (2 ** UP_SH + ARITY - 1) / ARITY;
  localparam int PROD_W = UP_SH + IDX_W + 1;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic signed [KEY_W-1:0] key_in;
  } in_word_t;

  typedef struct packed {
    status_t                 status;
    logic signed [KEY_W-1:0] removed_key;
    logic signed [KEY_W-1:0] new_min;
    logic [EC_W-1:0]         entry_count;
  } out_word_t;

  function automatic logic [IDX_W-1:0] parent_of(logic [IDX_W-1:0] pos);
    logic [IDX_W-1:0]  v;
    logic [PROD_W-1:0] p;
    v = pos - 1'b1;
    p = PROD_W'(v) * PROD_W'(UP_MUL);
    return p[UP_SH +: IDX_W];
  endfunction

  function automatic logic [CHW-1:0] first_child(logic [IDX_W-1:0] pos);
    return CHW'(pos) * CHW'(ARITY) + CHW'(1);
  endfunction

  function automatic logic [EC_W-1:0] ec_of(logic [CNT_W-1:0] c);
    logic [CNT_W+EC_W-1:0] w;
    w = {{EC_W{1'b0}}, c};
    return w[EC_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/dmhq_engine.sv
// Heap sequencer: key store memory, sift-up and sift-down control.
`default_nettype none
`include "dary_min_heap_queue_top_defines.svh"

module dmhq_engine
  import dmhq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire in_word_t  item,
  output logic           idle,
  output logic           res_valid,
  input  wire logic      res_take,
  output out_word_t      res
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_UP_LVL  = 8'b0000_0010,
    S_UP_CMP  = 8'b0000_0100,
    S_DEL_LD  = 8'b0000_1000,
    S_DN_LVL  = 8'b0001_0000,
    S_DN_SCAN = 8'b0010_0000,
    S_DONE    = 8'b0100_0000,
    S_SPARE   = 8'b1000_0000
  } state_t;

  logic [KEY_W-1:0] mem [CAPACITY];

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        pos_r, pos_nxt;
  logic [IDX_W-1:0]        par_r, par_nxt;
  logic [IDX_W-1:0]        last_r, last_nxt;
  logic [IDX_W-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]        best_idx_r, best_idx_nxt;
  logic                    best_vld_r, best_vld_nxt;
  logic signed [KEY_W-1:0] best_r, best_nxt;
  logic signed [KEY_W-1:0] x_r, x_nxt;
  logic signed [KEY_W-1:0] root_r, root_nxt;
  logic signed [KEY_W-1:0] removed_r, removed_nxt;
  status_t                 status_r, status_nxt;
  logic signed [KEY_W-1:0] rd_data_r;

  logic                    we, re;
  logic [IDX_W-1:0]        waddr, raddr;
  logic signed [KEY_W-1:0] wdata;
  logic [CNT_W-1:0]        cnt_m1;
  logic [CHW-1:0]          first_w, lastc_w, last_sel;
  logic                    take;
  logic signed [KEY_W-1:0] bk;
  logic [IDX_W-1:0]        bi;

  assign cnt_m1   = cnt_r - 1'b1;
  assign first_w  = first_child(pos_r);
  assign lastc_w  = first_w + CHW'(ARITY - 1);
  assign last_sel = (lastc_w >= CHW'(cnt_r)) ? CHW'(cnt_m1) : lastc_w;
  assign take     = !best_vld_r || (rd_data_r < best_r);
  assign bk       = take ? rd_data_r : best_r;
  assign bi       = take ? cmp_idx_r : best_idx_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    par_nxt      = par_r;
    last_nxt     = last_r;
    cmp_idx_nxt  = cmp_idx_r;
    best_idx_nxt = best_idx_r;
    best_vld_nxt = best_vld_r;
    best_nxt     = best_r;
    x_nxt        = x_r;
    removed_nxt  = removed_r;
    status_nxt   = status_r;
    we           = 1'b0;
    waddr        = pos_r;
    wdata        = x_r;
    re           = 1'b0;
    raddr        = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt  = ST_DONE;
          removed_nxt = '0;
          if (item.cmd == CMD_INSERT) begin
            if (cnt_r >= CNT_W'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              pos_nxt   = cnt_r[IDX_W-1:0];
              x_nxt     = item.key_in;
              cnt_nxt   = cnt_r + 1'b1;
              state_nxt = S_UP_LVL;
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              removed_nxt = root_r;
              cnt_nxt     = cnt_m1;
              if (cnt_m1 == '0) begin
                state_nxt = S_DONE;
              end else begin
                re        = 1'b1;
                raddr     = cnt_m1[IDX_W-1:0];
                state_nxt = S_DEL_LD;
              end
            end
          end
        end
      end
      S_UP_LVL: begin
        if (pos_r == '0) begin
          we        = 1'b1;
          state_nxt = S_DONE;
        end else begin
          par_nxt   = parent_of(pos_r);
          re        = 1'b1;
          raddr     = par_nxt;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (x_r < rd_data_r) begin
          wdata     = rd_data_r;
          pos_nxt   = par_r;
          state_nxt = S_UP_LVL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DEL_LD: begin
        x_nxt     = rd_data_r;
        pos_nxt   = '0;
        state_nxt = S_DN_LVL;
      end
      S_DN_LVL: begin
        if (first_w >= CHW'(cnt_r)) begin
          we        = 1'b1;
          state_nxt = S_DONE;
        end else begin
          re           = 1'b1;
          raddr        = first_w[IDX_W-1:0];
          cmp_idx_nxt  = first_w[IDX_W-1:0];
          last_nxt     = last_sel[IDX_W-1:0];
          best_vld_nxt = 1'b0;
          state_nxt    = S_DN_SCAN;
        end
      end
      S_DN_SCAN: begin
        best_nxt     = bk;
        best_idx_nxt = bi;
        best_vld_nxt = 1'b1;
        if (cmp_idx_r == last_r) begin
          we = 1'b1;
          if (bk < x_r) begin
            wdata     = bk;
            pos_nxt   = bi;
            state_nxt = S_DN_LVL;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          re          = 1'b1;
          raddr       = cmp_idx_r + 1'b1;
          cmp_idx_nxt = cmp_idx_r + 1'b1;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign root_nxt = (we && waddr == '0) ? wdata : root_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    par_r      <= par_nxt;
    last_r     <= last_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_vld_r <= best_vld_nxt;
    best_r     <= best_nxt;
    x_r        <= x_nxt;
    root_r     <= root_nxt;
    removed_r  <= removed_nxt;
    status_r   <= status_nxt;
  end

  assign idle            = (state_r == S_IDLE);
  assign res_valid       = (state_r == S_DONE);
  assign res.status      = status_r;
  assign res.removed_key = removed_r;
  assign res.new_min     = (cnt_r != '0) ? root_r : '0;
  assign res.entry_count = ec_of(cnt_r);

  `DMHQ_ASSERT_NEXT(a_start_busy, start && idle, !idle, "accepted word left engine idle")
  `DMHQ_ASSERT_NOW(a_wr_live, we, CNT_W'(waddr) < cnt_r, "write outside live entries")
  `DMHQ_ASSERT_NOW(a_rd_live, re && !idle, CNT_W'(raddr) < cnt_r, "read outside live entries")
  `DMHQ_ASSERT_NOW(a_cnt_cap, 1'b1, cnt_r <= CNT_W'(CAPACITY), "count above capacity")
  `DMHQ_ASSERT_NEXT(a_res_hold, res_valid && !res_take, res_valid && $stable(res),
                    "result changed before taken")

endmodule

`default_nettype wire

FILE: rtl/core/dary_min_heap_queue_top.sv
// Top level of the d-ary min-heap priority queue: handshakes and result register.
//
// Input channel in_valid/in_ready/in_word carries one command word: insert key_in,
// or delete the minimum. Result channel out_valid/out_ready/out_word returns one
// word per command: status, removed key, new root key and entry count.
// Commands are handled one at a time; in_ready is high while the heap sequencer
// is idle. The key store has a single read port, so the sequencer reads one key
// at a time; the result enters the output register in the same cycle that in_ready rises:
//   insert: for each level the key climbs (0..4), read the parent, then move it
//   down or stop; the key is written where it stops, at the latest at the root.
//   delete: load the last key, then per visited level read the live children one
//   by one and move the smallest up. Refused requests and removing the last key need no walk.
// The result lands in an output register; the next command is accepted while it
// waits. If out_ready stays low, the following result is held in the sequencer,
// which then stops accepting commands until the register drains.
// Reset empties the queue (count zero); key store contents need no clearing and
// are left as they are.
`default_nettype none

module dary_min_heap_queue_top
  import dmhq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_word
);

  logic      idle;
  logic      res_valid;
  logic      res_take;
  out_word_t res;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;

  dmhq_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_valid && idle),
    .item      (in_word),
    .idle      (idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  assign res_take      = res_valid && (!out_valid_r || out_ready);
  assign out_valid_nxt = res_take || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_word_r <= res;
    end
  end

  assign in_ready  = idle;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

FILE: verif/tb_dary_min_heap_queue_top.sv
// Self-checking testbench for the d-ary min-heap queue: random handshakes, heap predictor.
`timescale 1ns / 100ps

module tb_dary_min_heap_queue_top;
  import dmhq_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1350;
  localparam int IDLE_PCT     = 36;

  typedef struct {
    in_word_t word;
    bit       drain_first;
  } pending_cmd_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  pending_cmd_t            pending_cmds[$];
  out_word_t               expected_words[$];
  logic signed [KEY_W-1:0] heap_keys[CAPACITY];
  int                      heap_len       = 0;
  int                      mismatch_count = 0;
  int                      accepted_count = 0;
  int                      cycle_count    = 0;
  bit                      in_fire        = 1'b0;
  bit                      calm           = 1'b0;

  dary_min_heap_queue_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(string what);
    if (mismatch_count < 40) begin
      $display("[%0t] MISMATCH %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // heap model: applies one command word, returns the result word
  function automatic out_word_t heap_apply(in_word_t w);
    out_word_t               r;
    int                      pos;
    int                      parent;
    int                      first;
    int                      last;
    int                      best;
    logic signed [KEY_W-1:0] t;
    r = '0;
    r.status = ST_DONE;
    if (w.cmd == CMD_INSERT) begin
      if (heap_len >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        heap_keys[heap_len] = w.key_in;
        pos = heap_len;
        while (pos > 0) begin
          parent = (pos - 1) / ARITY;
          if (!(heap_keys[pos] < heap_keys[parent])) break;
          t = heap_keys[pos];
          heap_keys[pos] = heap_keys[parent];
          heap_keys[parent] = t;
          pos = parent;
        end
        heap_len++;
      end
    end else begin
      if (heap_len == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed_key = heap_keys[0];
        heap_len--;
        if (heap_len > 0) begin
          heap_keys[0] = heap_keys[heap_len];
          pos = 0;
          forever begin
            first = pos * ARITY + 1;
            if (first >= heap_len) break;
            last = first + ARITY - 1;
            if (last >= heap_len) last = heap_len - 1;
            best = first;
            for (int c = first + 1; c <= last; c++) begin
              if (heap_keys[c] < heap_keys[best]) best = c;
            end
            if (!(heap_keys[best] < heap_keys[pos])) break;
            t = heap_keys[pos];
            heap_keys[pos] = heap_keys[best];
            heap_keys[best] = t;
            pos = best;
          end
        end
      end
    end
    r.new_min     = (heap_len > 0) ? heap_keys[0] : '0;
    r.entry_count = EC_W'(heap_len);
    return r;
  endfunction

  function automatic logic signed [KEY_W-1:0] random_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       k = 32'sh8000_0000;
          1:       k = 32'sh7fff_ffff;
          2:       k = '0;
          default: k = -32'sd1;
        endcase
      end
      1, 2, 3: k = $signed(32'($urandom_range(0, 15))) - 32'sd8;
      default: k = $urandom;
    endcase
    return k;
  endfunction

  function automatic pending_cmd_t make_cmd(cmd_t c, logic signed [KEY_W-1:0] k, bit drain);
    pending_cmd_t p;
    p.word.cmd    = c;
    p.word.key_in = k;
    p.drain_first = drain;
    return p;
  endfunction

  // driver: new word at the falling edge once the previous one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (pending_cmds.size() == 0 ||
          (!calm && $urandom_range(0, 99) < IDLE_PCT) ||
          (pending_cmds[0].drain_first && expected_words.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_word  <= pending_cmds[0].word;
        in_valid <= 1'b1;
        void'(pending_cmds.pop_front());
      end
    end
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", out_word));
        end else begin
          exp_w = expected_words.pop_front();
          if (out_word.status !== exp_w.status)
            report_mismatch($sformatf("status %0d, want %0d", out_word.status, exp_w.status));
          if (out_word.removed_key !== exp_w.removed_key)
            report_mismatch($sformatf("removed_key %0d, want %0d",
                                      out_word.removed_key, exp_w.removed_key));
          if (out_word.new_min !== exp_w.new_min)
            report_mismatch($sformatf("new_min %0d, want %0d",
                                      out_word.new_min, exp_w.new_min));
          if (out_word.entry_count !== exp_w.entry_count)
            report_mismatch($sformatf("entry_count %0d, want %0d",
                                      out_word.entry_count, exp_w.entry_count));
        end
      end
      in_fire = in_valid && in_ready;
      if (in_fire) begin
        expected_words.push_back(heap_apply(in_word));
        accepted_count++;
      end
      calm = (accepted_count >= 600) && (accepted_count < 850);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int n;
    int run_len;
    int ins_pct;
    int phase;

    // directed: empty delete, extremes, equal keys, ignored key on delete
    pending_cmds.push_back(make_cmd(CMD_DELETE, '0, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_INSERT, '0, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, '0, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, 32'sh7fff_ffff, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 32'sh7fff_ffff, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 32'sh8000_0000, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_INSERT, -32'sd1, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 32'sd1, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 32'sd5, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 32'sd5, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 32'sd5, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 32'sd5, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 32'sh8000_0000, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, -32'sd1, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, 32'sh5555_aaaa, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_DELETE, '0, 1'b0));
    pending_cmds.push_back(make_cmd(CMD_INSERT, 32'sd5, 1'b0));
    for (int i = 0; i < 9; i++) begin
      pending_cmds.push_back(make_cmd(CMD_DELETE, '0, 1'b0));
    end

    // random: runs biased toward filling, draining or mixing
    n = 0;
    phase = 0;
    while (n < RANDOM_ITEMS) begin
      if (phase == 0) begin
        ins_pct = 95;
        run_len = 90;
      end else begin
        case ($urandom_range(0, 4))
          0:       ins_pct = 92;
          1:       ins_pct = 8;
          2:       ins_pct = 50;
          3:       ins_pct = 65;
          default: ins_pct = 35;
        endcase
        run_len = $urandom_range(20, 80);
      end
      for (int i = 0; i < run_len; i++) begin
        pending_cmds.push_back(make_cmd(
          ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_DELETE,
          random_key(),
          (i == 0) && (phase == 1 || $urandom_range(0, 2) == 0)));
      end
      n += run_len;
      phase++;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_cmds.size() == 0);
    @(posedge clk);
    wait (!in_valid && expected_words.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/dmhq_pkg.sv
rtl/core/dmhq_engine.sv
rtl/core/dary_min_heap_queue_top.sv
verif/tb_dary_min_heap_queue_top.sv
